### src/char_lcd_nibble_sequencer_assert.svh
// Assertion macros shared by the character LCD sequencer RTL.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define CLCD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clcd assertion failed");

// Next-cycle implication, checked while out of reset.
`define CLCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clcd assertion failed");

`endif

### src/clcd_pkg.sv
// Types, constants and step tables for the character LCD nibble sequencer.
package clcd_pkg;

    typedef enum logic [1:0] {
        KIND_INIT   = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_CURSOR = 2'd3
    } kind_t;

    localparam int INIT_STEPS  = 11;
    localparam int STEP_W      = $clog2(INIT_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int WAIT_W      = 14;

    localparam logic [WAIT_W-1:0] WAIT_BYTE_US    = 14'd2000;
    localparam logic [WAIT_W-1:0] WAIT_POWERUP_US = 14'd15000;
    localparam logic [WAIT_W-1:0] WAIT_NONE_US    = 14'd0;
    localparam logic [6:0]        ROW1_BASE       = 7'h40;
    localparam logic [7:0]        CMD_SET_DDRAM   = 8'h80;

    // One classified request as it sits in the queue.
    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] value;
    } req_t;

    // One bus step.
    typedef struct packed {
        logic              strobe;
        logic              rs;
        logic [3:0]        nibble;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } step_t;

    // Queue status seen by the front, the back and the top level.
    typedef struct packed {
        logic              full;
        logic              empty;
    } q_status_t;

    // Sequencer status of the back part.
    typedef struct packed {
        logic [STEP_W-1:0] step_idx;
        logic              pop;
    } back_status_t;

    function automatic step_t mk_step(input logic strobe, input logic rs,
                                      input logic [3:0] nibble,
                                      input logic [WAIT_W-1:0] wait_us,
                                      input logic last);
        step_t s;
        s.strobe  = strobe;
        s.rs      = rs;
        s.nibble  = nibble;
        s.wait_us = wait_us;
        s.last    = last;
        return s;
    endfunction

    // Power-up sequence: wait, 0x3 x3, 0x2, then 0x28, 0x0F, 0x01 as nibble pairs.
    function automatic step_t init_step(input logic [STEP_W-1:0] idx);
        step_t s;
        case (idx)
            4'd0:    s = mk_step(1'b0, 1'b0, 4'h0, WAIT_POWERUP_US, 1'b0);
            4'd1:    s = mk_step(1'b1, 1'b0, 4'h3, 14'd5000, 1'b0);
            4'd2:    s = mk_step(1'b1, 1'b0, 4'h3, 14'd120, 1'b0);
            4'd3:    s = mk_step(1'b1, 1'b0, 4'h3, WAIT_BYTE_US, 1'b0);
            4'd4:    s = mk_step(1'b1, 1'b0, 4'h2, WAIT_BYTE_US, 1'b0);
            4'd5:    s = mk_step(1'b1, 1'b0, 4'h2, WAIT_NONE_US, 1'b0);
            4'd6:    s = mk_step(1'b1, 1'b0, 4'h8, WAIT_BYTE_US, 1'b0);
            4'd7:    s = mk_step(1'b1, 1'b0, 4'h0, WAIT_NONE_US, 1'b0);
            4'd8:    s = mk_step(1'b1, 1'b0, 4'hF, WAIT_BYTE_US, 1'b0);
            4'd9:    s = mk_step(1'b1, 1'b0, 4'h0, WAIT_NONE_US, 1'b0);
            4'd10:   s = mk_step(1'b1, 1'b0, 4'h1, WAIT_BYTE_US + WAIT_BYTE_US, 1'b1);
            default: s = mk_step(1'b1, 1'b0, 4'h1, WAIT_BYTE_US + WAIT_BYTE_US, 1'b1);
        endcase
        return s;
    endfunction

endpackage

### src/clcd_front.sv
// Front part: accepts requests and classifies them into queue entries.
module clcd_front
    import clcd_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,   // byte_value[7:0], row[8], column[14:9], zero pad
    input  logic [1:0] s_tuser,    // kind[1:0]
    input  q_status_t  q_status,
    output logic       push,
    output req_t       req
);

    kind_t      kind;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] column;
    logic [6:0] ddram_addr;

    assign kind       = kind_t'(s_tuser);
    assign byte_value = s_tdata[7:0];
    assign row        = s_tdata[8];
    assign column     = s_tdata[14:9];

    // Row base plus column stays within 7 bits, so no wrap.
    assign ddram_addr = (row ? ROW1_BASE : 7'h00) + {1'b0, column};

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    always_comb begin
        req.init  = 1'b0;
        req.rs    = 1'b0;
        req.value = byte_value;
        case (kind)
            KIND_INIT: begin
                req.init = 1'b1;
            end
            KIND_CMD: begin
                req.rs = 1'b0;
            end
            KIND_DATA: begin
                req.rs = 1'b1;
            end
            KIND_CURSOR: begin
                req.value = CMD_SET_DDRAM | {1'b0, ddram_addr};
            end
            default: begin
                req.init = 1'b0;
            end
        endcase
    end

endmodule

### src/clcd_queue.sv
// Short request queue between the front and back parts.
module clcd_queue
    import clcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  req_t      push_req,
    input  logic      pop,
    output req_t      head,
    output q_status_t status
);

    req_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

### src/clcd_back.sv
// Back part: steps through the head request and drives the output register.
module clcd_back
    import clcd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  req_t         head,
    input  q_status_t    q_status,
    output back_status_t status,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // nibble[3:0], wait_after_us[17:4], zero pad
    output logic [1:0]   m_tuser,   // strobe_res[0], reg_select[1]
    output logic         m_tlast
);

    logic [STEP_W-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    step_t             step_reg, step_next;
    step_t             cur;
    logic              advance, load;

    always_comb begin
        if (head.init) begin
            cur = init_step(idx_reg);
        end else if (idx_reg == '0) begin
            cur = mk_step(1'b1, head.rs, head.value[7:4], WAIT_NONE_US, 1'b0);
        end else begin
            cur = mk_step(1'b1, head.rs, head.value[3:0], WAIT_BYTE_US, 1'b1);
        end
    end

    assign advance = !valid_reg || m_tready;
    assign load    = advance && !q_status.empty;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        step_next  = step_reg;
        if (advance) begin
            valid_next = load;
        end
        if (load) begin
            step_next = cur;
            idx_next  = cur.last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
    end

    assign status.step_idx = idx_reg;
    assign status.pop      = load && cur.last;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, step_reg.wait_us, step_reg.nibble};
    assign m_tuser  = {step_reg.rs, step_reg.strobe};
    assign m_tlast  = step_reg.last;

endmodule

### src/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer.
// Turns requests (init, command byte, data byte, cursor move) into 4-bit bus
// steps for an HD44780-style display, one step per output transaction, each
// with its strobe flag, register select, nibble and the wait in microseconds
// that must follow it; tlast marks a request's final step. A request enters a
// two-entry queue in the cycle it is accepted, and the back sequencer emits one
// step per cycle from its step counter while m_tready allows: two steps for a
// byte or cursor move, eleven for init. The first step passes through the queue
// and then the output step register; the queue lets new requests be taken
// while an earlier one is still being stepped out or held by m_tready.
module char_lcd_nibble_sequencer
    import clcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_value[7:0], row[8], column[14:9], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // nibble[3:0], wait_after_us[17:4], zero pad
    output logic [1:0]  m_tuser,   // strobe_res[0], reg_select[1]
    output logic        m_tlast
);

`include "char_lcd_nibble_sequencer_assert.svh"

    q_status_t    q_status;
    back_status_t b_status;
    logic         push;
    req_t         push_req;
    req_t         head;

    clcd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .req      (push_req)
    );

    clcd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (b_status.pop),
        .head     (head),
        .status   (q_status)
    );

    clcd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .status   (b_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A run in progress always has its request at the queue head.
    `CLCD_ASSERT_NOW(a_run_has_head, aclk, aresetn, b_status.step_idx != '0, !q_status.empty)
    // A full queue takes nothing.
    `CLCD_ASSERT_NOW(a_full_no_ready, aclk, aresetn, q_status.full, !s_tready)
    // The only wait-only step is the power-up wait that opens init.
    `CLCD_ASSERT_NOW(a_wait_only_step, aclk, aresetn, m_tvalid && !m_tuser[0],
        !m_tlast && (m_tdata[17:4] == WAIT_POWERUP_US) && !m_tuser[1])
    // The queue drains one request only as its final step is loaded.
    `CLCD_ASSERT_NEXT(a_pop_gives_last, aclk, aresetn, b_status.pop, m_tvalid && m_tlast)

endmodule
